/* src/fpem_pkg.sv */
// Package for the front-panel encoder menu: payload structs, constants, preset and limit tables.
// No dependencies.
`default_nettype none
package fpem_pkg;
	localparam int ParamsPerMode = 9;
	localparam int MenuItems = 11;
	localparam int PresetModes = 5;
	localparam int DefNumModes = 5;
	localparam logic [8:0] BlinkHalf = 9'd250;
	localparam logic [8:0] BlinkLast = 9'd499;

	localparam logic [1:0] UiWork = 2'd0;
	localparam logic [1:0] UiSelect = 2'd1;
	localparam logic [1:0] UiEdit = 2'd2;

	localparam logic [1:0] KindNumber = 2'd0;
	localparam logic [1:0] KindLabel = 2'd1;
	localparam logic [1:0] KindBlank = 2'd2;

	localparam logic [3:0] ItemSaveExit = 4'd9;
	localparam logic [3:0] ItemExit = 4'd10;
	localparam logic [3:0] ItemLast = 4'd10;

	localparam logic [2:0] PhIdle = 3'd0;
	localparam logic [2:0] PhStartHf = 3'd2;
	localparam logic [2:0] PhWeld = 3'd3;
	localparam logic [2:0] PhPostGas = 3'd6;

	localparam logic [2:0] CfgLongPress = 3'd0;
	localparam logic [2:0] CfgClickMin = 3'd1;
	localparam logic [2:0] CfgSaveIdle = 3'd2;
	localparam logic [2:0] CfgCurMin = 3'd3;
	localparam logic [2:0] CfgCurMax = 3'd4;
	localparam logic [2:0] CfgCurStep = 3'd5;

	typedef struct packed {
		logic        button_pressed;
		logic [1:0]  encoder_phases;
		logic [2:0]  machine_phase;
		logic [15:0] phase_age_ms;
		logic [9:0]  measured_current;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  ui_state;
		logic [2:0]  mode_index;
		logic [7:0]  set_current;
		logic [3:0]  menu_index;
		logic [14:0] shown_value;
		logic [1:0]  show_kind;
		logic        save_request;
	} out_item_t;

	// Factory preset for one mode and item; modes beyond the table get zero.
	function automatic logic [14:0] preset(input int m, input int k);
		logic [14:0] t [0:44];
		t = '{15'd300, 15'd40, 15'd500, 15'd2000, 15'd3000, 15'd0, 15'd0, 15'd0, 15'd0,
			15'd300, 15'd30, 15'd300, 15'd1500, 15'd5000, 15'd200, 15'd200, 15'd0, 15'd0,
			15'd200, 15'd60, 15'd0, 15'd0, 15'd2000, 15'd40, 15'd600, 15'd0, 15'd0,
			15'd300, 15'd80, 15'd0, 15'd0, 15'd2000, 15'd1200, 15'd0, 15'd0, 15'd0,
			15'd400, 15'd50, 15'd1000, 15'd3000, 15'd4000, 15'd0, 15'd0, 15'd100, 15'd30};
		if (m >= PresetModes) return 15'd0;
		return t[m * ParamsPerMode + k];
	endfunction

	function automatic logic [14:0] p_step(input logic [3:0] k);
		case (k)
			4'd0: return 15'd100; 4'd1: return 15'd5; 4'd2: return 15'd100;
			4'd3: return 15'd100; 4'd4: return 15'd100; 4'd5: return 15'd10;
			4'd6: return 15'd10; 4'd7: return 15'd5; 4'd8: return 15'd1;
			default: return 15'd0;
		endcase
	endfunction

	function automatic logic [14:0] p_high(input logic [3:0] k);
		case (k)
			4'd0: return 15'd2000; 4'd1: return 15'd100; 4'd2: return 15'd5000;
			4'd3: return 15'd10000; 4'd4: return 15'd20000; 4'd5: return 15'd1000;
			4'd6: return 15'd1000; 4'd7: return 15'd200; 4'd8: return 15'd50;
			default: return 15'd0;
		endcase
	endfunction

	function automatic logic [14:0] p_low(input logic [3:0] k);
		case (k)
			4'd0: return 15'd100; 4'd1: return 15'd10; 4'd2: return 15'd0;
			4'd3: return 15'd0; 4'd4: return 15'd100; 4'd5: return 15'd10;
			4'd6: return 15'd10; 4'd7: return 15'd20; 4'd8: return 15'd10;
			default: return 15'd0;
		endcase
	endfunction
endpackage
`default_nettype wire

/* src/fpem_param_mem.sv */
// Parameter store: NUM_MODES x 9 words with a registered read and a clearing pass
// that loads the factory presets after reset. Depends on fpem_pkg.
`default_nettype none
module fpem_param_mem #(
	parameter int NUM_MODES = 5,
	parameter int DEPTH = NUM_MODES * 9,
	parameter int AW = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [AW-1:0] raddr,
	output logic [14:0]        rdata,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [14:0]   wdata,
	output logic               init_done
);
	import fpem_pkg::*;

	logic [14:0] mem [0:DEPTH-1];
	logic [AW:0] fill_q;
	logic [14:0] fill_val;

	// Preset value for the entry under the fill pointer.
	always_comb begin
		fill_val = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (fill_q[AW-1:0] == AW'(i)) begin
				fill_val = preset(i / ParamsPerMode, i % ParamsPerMode);
			end
		end
	end

	assign init_done = (fill_q == (AW + 1)'(DEPTH));

	// Fill pointer walks the memory once after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (!init_done) begin
			fill_q <= fill_q + 1'b1;
		end
	end

	// Single write port, registered read.
	always_ff @(posedge clk) begin
		if (!init_done) begin
			mem[fill_q[AW-1:0]] <= fill_val;
		end else if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* src/front_panel_encoder_menu.sv */
// Top level of the front-panel encoder menu: button, encoder, save logic and display.
// Depends on fpem_pkg and fpem_param_mem.
`default_nettype none
// Channel  | valid     | stall     | payload
// input    | in_valid  | in_stall  | in_item  (in_item_t)
// output   | out_valid | out_stall | out_item (out_item_t)
// config   | cfg_we    | -         | cfg_index, cfg_data
// One transaction per cycle while no stall is raised; a result passes through the stage 1
// registers and then the output register before it can be taken.
// Stage 1 updates all register state and reads the parameter memory; stage 2 edits the
// read word, writes it back and builds the result in the output register.
// After reset a pass over all NUM_MODES*9 entries loads the presets; no input is taken meanwhile.
// A stall on the output holds both stages and raises in_stall.
module front_panel_encoder_menu #(
	parameter int NUM_MODES = fpem_pkg::DefNumModes
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire fpem_pkg::in_item_t  in_item,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output fpem_pkg::out_item_t      out_item,
	input  wire logic                cfg_we,
	input  wire logic [2:0]          cfg_index,
	input  wire logic [15:0]         cfg_data
);
	import fpem_pkg::*;

	localparam int Depth = NUM_MODES * ParamsPerMode;
	localparam int Aw = $clog2(Depth);
	localparam int Mw = (NUM_MODES > 1) ? $clog2(NUM_MODES) : 1;

	logic [15:0] long_press_q, click_min_q, save_idle_q;
	logic [7:0]  cur_min_q, cur_max_q, cur_step_q;

	logic [7:0]  setpoint_q;
	logic [2:0]  mode_q;
	logic [1:0]  ui_q;
	logic [3:0]  menu_q;
	logic        held_q, lp_done_q, pending_q, arc_q;
	logic [15:0] press_q;
	logic [1:0]  prev_q;
	logic [8:0]  blink_q;

	logic        v_s1;
	logic        edit_s1, dir_up_s1, blank_s1, param_ok_s1;
	logic [3:0]  item_s1;
	logic [Aw-1:0] addr_s1;
	out_item_t   res_s1;

	logic        init_done, adv;
	logic [14:0] rdata, fwd_val, cur_val, new_val;
	logic        we;
	logic [Aw-1:0] raddr;
	logic [Aw-1:0] waddr_w;
	out_item_t   out_next;

	// Pipeline advances unless the output register is full and stalled.
	assign adv = !(out_valid && out_stall);
	assign in_stall = !adv || !init_done;
	wire take = in_valid && !in_stall;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_press_q <= 16'd1200;
			click_min_q <= 16'd50;
			save_idle_q <= 16'd10000;
			cur_min_q <= 8'd10;
			cur_max_q <= 8'd250;
			cur_step_q <= 8'd5;
		end else if (cfg_we) begin
			case (cfg_index)
				CfgLongPress: long_press_q <= cfg_data;
				CfgClickMin: click_min_q <= cfg_data;
				CfgSaveIdle: save_idle_q <= cfg_data;
				CfgCurMin: cur_min_q <= cfg_data[7:0];
				CfgCurMax: cur_max_q <= cfg_data[7:0];
				CfgCurStep: cur_step_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Next-state logic for one tick.
	logic [7:0]  n_setpoint;
	logic [2:0]  n_mode;
	logic [1:0]  n_ui;
	logic [3:0]  n_menu;
	logic        n_held, n_lp, n_pending, n_arc, n_save, step_up, step_dn;
	logic [15:0] n_press;
	logic [8:0]  n_blink;
	logic [9:0]  sum;
	logic [14:0] shown;
	logic [1:0]  kind;
	logic [2:0]  ph;

	always_comb begin
		ph = in_item.machine_phase;
		n_setpoint = setpoint_q; n_mode = mode_q; n_ui = ui_q; n_menu = menu_q;
		n_held = held_q; n_lp = lp_done_q; n_pending = pending_q; n_arc = arc_q;
		n_press = press_q; n_save = 1'b0; sum = '0;
		n_blink = (blink_q == BlinkLast) ? 9'd0 : blink_q + 9'd1;

		// Button.
		if (in_item.button_pressed) begin
			if (!held_q) begin
				n_held = 1'b1; n_press = '0; n_lp = 1'b0;
			end else if (press_q != 16'hFFFF) begin
				n_press = press_q + 16'd1;
			end
			if (!n_lp && n_press > long_press_q) begin
				n_ui = (ui_q == UiWork) ? UiSelect : UiWork;
				n_menu = '0;
				n_lp = 1'b1;
			end
		end else if (held_q) begin
			if (!lp_done_q && press_q > click_min_q) begin
				case (ui_q)
					UiWork: begin
						n_mode = (mode_q == 3'(NUM_MODES - 1)) ? 3'd0 : mode_q + 3'd1;
						n_pending = 1'b1;
					end
					UiSelect: begin
						if (menu_q == ItemSaveExit) begin
							n_save = 1'b1; n_ui = UiWork;
						end else if (menu_q == ItemExit) begin
							n_ui = UiWork;
						end else begin
							n_ui = UiEdit;
						end
					end
					default: n_ui = UiSelect;
				endcase
			end
			n_held = 1'b0; n_lp = 1'b0; n_press = '0;
		end

		// Encoder detents.
		step_up = (prev_q == 2'd0) && (in_item.encoder_phases == 2'd1);
		step_dn = (prev_q == 2'd0) && (in_item.encoder_phases == 2'd2);
		if (step_up || step_dn) begin
			case (n_ui)
				UiWork: begin
					sum = step_up ? {2'b0, setpoint_q} + {2'b0, cur_step_q}
						: {2'b0, setpoint_q} - {2'b0, cur_step_q};
					if (!sum[9] && sum > {2'b0, cur_max_q}) sum = {2'b0, cur_max_q};
					if (sum[9] || sum < {2'b0, cur_min_q}) sum = {2'b0, cur_min_q};
					n_setpoint = sum[7:0];
					n_pending = 1'b1;
				end
				UiSelect: begin
					if (step_up) n_menu = (n_menu == ItemLast) ? 4'd0 : n_menu + 4'd1;
					else n_menu = (n_menu == 4'd0) ? ItemLast : n_menu - 4'd1;
				end
				default: n_pending = 1'b1;
			endcase
		end

		// Arc tracking and deferred save.
		if (ph == PhWeld || ph == PhStartHf) n_arc = 1'b1;
		if (n_pending && ph == PhIdle && (n_arc || in_item.phase_age_ms > save_idle_q)) begin
			n_save = 1'b1; n_pending = 1'b0; n_arc = 1'b0;
		end

		// Display, except the parameter word which stage 2 fills in.
		shown = '0; kind = KindNumber;
		case (n_ui)
			UiWork: shown = (ph == PhIdle || ph == PhPostGas) ? {7'b0, n_setpoint}
				: {5'b0, in_item.measured_current};
			UiSelect: begin shown = {11'b0, n_menu}; kind = KindLabel; end
			default: if (blink_q >= BlinkHalf) kind = KindBlank;
		endcase
	end

	// Stage 1: register state and result skeleton.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q <= 8'd120; mode_q <= '0; ui_q <= UiWork; menu_q <= '0;
			held_q <= 1'b0; lp_done_q <= 1'b0; pending_q <= 1'b0; arc_q <= 1'b0;
			press_q <= '0; prev_q <= '0; blink_q <= '0; v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= take;
			if (take) begin
				setpoint_q <= n_setpoint; mode_q <= n_mode; ui_q <= n_ui; menu_q <= n_menu;
				held_q <= n_held; lp_done_q <= n_lp; pending_q <= n_pending; arc_q <= n_arc;
				press_q <= n_press; prev_q <= in_item.encoder_phases; blink_q <= n_blink;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s1 <= '{ui_state: n_ui, mode_index: n_mode, set_current: n_setpoint,
				menu_index: n_menu, shown_value: shown, show_kind: kind, save_request: n_save};
			edit_s1 <= (n_ui == UiEdit) && (step_up || step_dn);
			dir_up_s1 <= step_up;
			blank_s1 <= (n_ui == UiEdit) && (blink_q >= BlinkHalf);
			param_ok_s1 <= (n_menu < 4'(ParamsPerMode)) && ({1'b0, n_mode} < 4'(NUM_MODES));
			item_s1 <= n_menu;
			addr_s1 <= raddr;
		end
	end

	// Memory address of the current mode and item.
	always_comb begin
		raddr = Aw'(n_mode[Mw-1:0] * ParamsPerMode + n_menu);
		if (!((n_menu < 4'(ParamsPerMode)) && ({1'b0, n_mode} < 4'(NUM_MODES)))) raddr = '0;
	end

	// Forward the word written by stage 2 when stage 1 reads the same entry.
	logic          fwd_hit_q;
	logic [14:0]   fwd_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_hit_q <= 1'b0;
		end else if (adv) begin
			fwd_hit_q <= we && (waddr_w == raddr);
		end
	end
	always_ff @(posedge clk) begin
		if (adv) fwd_q <= new_val;
	end

	assign waddr_w = addr_s1;
	assign cur_val = fwd_hit_q ? fwd_q : rdata;
	assign fwd_val = cur_val;

	// Stage 2: parameter edit.
	always_comb begin
		new_val = fwd_val;
		if (dir_up_s1 && fwd_val < p_high(item_s1)) new_val = fwd_val + p_step(item_s1);
		if (!dir_up_s1 && fwd_val > p_low(item_s1)) new_val = fwd_val - p_step(item_s1);
	end
	assign we = v_s1 && adv && edit_s1 && param_ok_s1;

	// The read is held stable under a stall by re-reading the same address.
	fpem_param_mem #(.NUM_MODES(NUM_MODES), .DEPTH(Depth), .AW(Aw)) u_mem (
		.clk(clk), .arst_n(arst_n),
		.raddr(adv ? raddr : addr_s1), .rdata(rdata),
		.we(we), .waddr(waddr_w), .wdata(new_val), .init_done(init_done)
	);

	// Final result: the parameter word replaces the shown value while editing.
	always_comb begin
		out_next = res_s1;
		if (res_s1.ui_state == UiEdit && !blank_s1) begin
			out_next.shown_value = param_ok_s1 ? (edit_s1 ? new_val : cur_val) : 15'd0;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			out_item <= out_next;
		end
	end

	// Checks.
	a_no_take_in_init: assert property (@(posedge clk) disable iff (!arst_n)
		!init_done |-> in_stall) else $error("input taken during preset load");
	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item)) else $error("output dropped");
	a_ui_legal: assert property (@(posedge clk) disable iff (!arst_n)
		ui_q != 2'd3) else $error("bad ui state");
	a_blink_range: assert property (@(posedge clk) disable iff (!arst_n)
		blink_q <= BlinkLast) else $error("blink out of range");
endmodule
`default_nettype wire
